// ----- design/cate_pkg.sv -----
// shared types and constants for the counter and alarm tick engine
// no dependencies
package cate_pkg;
  localparam int NUM_COUNTERS = 8;
  localparam int NUM_ALARMS   = 16;
  localparam int TICK_WIDTH   = 32;
  localparam int CNT_IDX_W    = 3;
  localparam int ALM_IDX_W    = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_READ    = 3'd1;
  localparam logic [2:0] MODE_ELAPSED = 3'd2;
  localparam logic [2:0] MODE_SETMAX  = 3'd3;
  localparam logic [2:0] MODE_ARM     = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_BAD_REF = 2'd2;

  localparam logic CFG_COUNTERS = 1'b0;
  localparam logic CFG_ALARMS   = 1'b1;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_TICK, OP_READ, OP_ELAPSED, OP_SETMAX, OP_ARM, OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [1:0]            status;
    logic [CNT_IDX_W-1:0]  cid;
    logic [ALM_IDX_W-1:0]  aidx;
    logic [TICK_WIDTH-1:0] refv;
    logic [TICK_WIDTH-1:0] cyc;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [TICK_WIDTH-1:0] value;
    logic [TICK_WIDTH-1:0] nref;
    logic [ALM_IDX_W-1:0]  alarm;
    logic                  exp_valid;
    logic                  last;
  } res_t;
endpackage

// ----- design/cate_front.sv -----
// front end: accepts items, checks counter id against config, queues commands
// depends on cate_pkg
module cate_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic [2:0]           counter_id_i,
  input  logic [3:0]           alarm_index_i,
  input  logic [31:0]          ref_value_i,
  input  logic [31:0]          cycle_ticks_i,
  input  logic [3:0]           counters_in_use_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cate_pkg::cmd_t       cmd_o
);
  import cate_pkg::*;

  cmd_t       queue_q [QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  cmd_t       cmd_d;
  logic       push, pop;

  // classify
  always_comb begin
    cmd_d.cid    = counter_id_i;
    cmd_d.aidx   = alarm_index_i;
    cmd_d.refv   = ref_value_i;
    cmd_d.cyc    = cycle_ticks_i;
    cmd_d.status = ST_OK;
    case (mode_i)
      MODE_TICK:    cmd_d.op = OP_TICK;
      MODE_READ:    cmd_d.op = OP_READ;
      MODE_ELAPSED: cmd_d.op = OP_ELAPSED;
      MODE_SETMAX:  cmd_d.op = OP_SETMAX;
      MODE_ARM:     cmd_d.op = OP_ARM;
      default:      cmd_d.op = OP_REJECT;
    endcase
    if (cmd_d.op != OP_REJECT && {1'b0, counter_id_i} >= counters_in_use_i) begin
      cmd_d.op     = OP_REJECT;
      cmd_d.status = ST_BAD_ID;
    end
  end

  assign in_ready_o  = (fill_q != 2'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cmd_d;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- design/cate_back.sv -----
// back end: counter and alarm state, executes commands, scans one alarm per cycle while the output is free
// depends on cate_pkg
module cate_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cate_pkg::cmd_t       cmd_i,
  input  logic [4:0]           alarms_in_use_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output cate_pkg::res_t       res_o
);
  import cate_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL} state_e;

  state_e                state_q;
  logic [TICK_WIDTH-1:0] cval_q [NUM_COUNTERS];
  logic [TICK_WIDTH-1:0] cmax_q [NUM_COUNTERS];
  logic                  act_q  [NUM_ALARMS];
  logic [TICK_WIDTH-1:0] rem_q  [NUM_ALARMS];
  logic [TICK_WIDTH-1:0] per_q  [NUM_ALARMS];
  logic [CNT_IDX_W-1:0]  own_q  [NUM_ALARMS];
  logic [ALM_IDX_W:0]    scan_q;
  logic [CNT_IDX_W-1:0]  cid_q;
  logic                  res_valid_q;
  res_t                  res_q;

  logic [ALM_IDX_W:0]    nal;
  logic [ALM_IDX_W-1:0]  si;
  logic [TICK_WIDTH-1:0] rem_dec, cur_v, cmax_v, inc_v, elapsed;
  logic                  hit, expire, out_free;
  res_t                  idle_res;

  assign nal      = (alarms_in_use_i > 5'(NUM_ALARMS)) ? 5'(NUM_ALARMS) : alarms_in_use_i;
  assign si       = scan_q[ALM_IDX_W-1:0];
  assign out_free = !res_valid_q || res_ready_i;
  assign hit      = act_q[si] && own_q[si] == cid_q;
  assign rem_dec  = (rem_q[si] != '0) ? rem_q[si] - 1'b1 : '0;
  assign expire   = hit && rem_dec == '0;
  assign cur_v    = cval_q[cmd_i.cid];
  assign cmax_v   = cmax_q[cmd_i.cid];
  assign inc_v    = (cur_v + 1'b1 > cmax_v) ? '0 : cur_v + 1'b1;
  assign elapsed  = (cur_v >= cmd_i.refv) ? cur_v - cmd_i.refv
                                          : cmax_v - cmd_i.refv + cur_v + 1'b1;

  assign cmd_ready_o = state_q == S_IDLE && out_free;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // single result for every command other than tick
  always_comb begin
    idle_res = '{status: cmd_i.status, value: '0, nref: '0, alarm: '0,
                 exp_valid: 1'b0, last: 1'b1};
    case (cmd_i.op)
      OP_READ: idle_res.value = cur_v;
      OP_ELAPSED: begin
        if (cmd_i.refv > cmax_v) idle_res.status = ST_BAD_REF;
        else begin
          idle_res.value = elapsed;
          idle_res.nref  = cur_v;
        end
      end
      default: ;
    endcase
  end

  // sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      scan_q      <= '0;
      cid_q       <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cval_q[i] <= '0;
        cmax_q[i] <= '1;
      end
      for (int i = 0; i < NUM_ALARMS; i++) begin
        act_q[i] <= 1'b0;
        rem_q[i] <= '0;
        per_q[i] <= '0;
        own_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && out_free) begin
            res_q       <= idle_res;
            res_valid_q <= (cmd_i.op != OP_TICK);
            case (cmd_i.op)
              OP_TICK: begin
                cval_q[cmd_i.cid] <= inc_v;
                cid_q       <= cmd_i.cid;
                scan_q      <= '0;
                state_q     <= S_SCAN;
              end
              OP_SETMAX: begin
                cmax_q[cmd_i.cid] <= cmd_i.refv;
                cval_q[cmd_i.cid] <= '0;
              end
              OP_ARM: begin
                act_q[cmd_i.aidx] <= 1'b1;
                rem_q[cmd_i.aidx] <= cmd_i.refv;
                per_q[cmd_i.aidx] <= cmd_i.cyc;
                own_q[cmd_i.aidx] <= cmd_i.cid;
              end
              default: ;
            endcase
          end else if (res_ready_i) res_valid_q <= 1'b0;
        end
        S_SCAN: begin
          if (scan_q >= nal) begin
            state_q <= S_FINAL;
            if (res_ready_i) res_valid_q <= 1'b0;
          end else if (out_free) begin
            if (hit) begin
              if (expire) begin
                if (per_q[si] != '0) rem_q[si] <= per_q[si];
                else begin
                  rem_q[si] <= rem_dec;
                  act_q[si] <= 1'b0;
                end
                res_q <= '{status: ST_OK, value: '0, nref: '0, alarm: si,
                           exp_valid: 1'b1, last: 1'b0};
              end else rem_q[si] <= rem_dec;
            end
            res_valid_q <= expire;
            scan_q      <= scan_q + 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            res_q       <= '{status: ST_OK, value: cval_q[cid_q], nref: '0, alarm: '0,
                             exp_valid: 1'b0, last: 1'b1};
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/counter_alarm_tick_engine_unit.sv -----
// counter and alarm tick engine top level: front classifier, 2-entry queue, back executor
// non-tick items pass the queue and result register, one per cycle while output is free
// a tick holds the back end through accept, a scan of one alarm entry per cycle while
// the output is free, end of scan, then the final result
// reset clears all counters, maxima to all ones, alarms inactive; config to 8 and 16
// depends on cate_pkg, cate_front, cate_back
module counter_alarm_tick_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // {cycle_ticks, ref_value, alarm_index, counter_id, mode} from bit 0: 3,3,4,32,32 + pad
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], result_value[33:2], new_reference[65:34], expired_alarm[69:66], pad
  output logic [71:0] m_axis_tdata,
  // expired_valid
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cate_pkg::*;

  logic [3:0] cnt_use_q;
  logic [4:0] alm_use_q;
  logic [3:0] ncnt;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  res_t       res;

  assign cfg_ready_o = 1'b1;
  assign ncnt = (cnt_use_q > 4'(NUM_COUNTERS)) ? 4'(NUM_COUNTERS) : cnt_use_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_use_q <= 4'd8;
      alm_use_q <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COUNTERS: cnt_use_q <= cfg_data_i[3:0];
        CFG_ALARMS:   alm_use_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  cate_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .mode_i           (s_axis_tdata[2:0]),
    .counter_id_i     (s_axis_tdata[5:3]),
    .alarm_index_i    (s_axis_tdata[9:6]),
    .ref_value_i      (s_axis_tdata[41:10]),
    .cycle_ticks_i    (s_axis_tdata[73:42]),
    .counters_in_use_i(ncnt),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_o            (cmd)
  );

  cate_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .alarms_in_use_i(alm_use_q),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_o          (res)
  );

  assign m_axis_tdata = {2'b00, res.alarm, res.nref, res.value, res.status};
  assign m_axis_tuser = res.exp_valid;
  assign m_axis_tlast = res.last;
endmodule

// ----- verif/tb.sv -----
// testbench for the counter and alarm tick engine: directed and random requests
// checked against an in-bench predictor of counters and alarms; depends on cate_pkg
`timescale 1ns / 1ps

module tb;
  import cate_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [31:0] nref;
    logic [3:0]  alarm;
    logic        exp_valid;
    logic        last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  // predicted state
  logic [3:0]  p_ncnt;
  logic [4:0]  p_nal;
  logic [31:0] cnt_val [NUM_COUNTERS];
  logic [31:0] cnt_max [NUM_COUNTERS];
  logic        alm_on [NUM_ALARMS];
  logic [31:0] alm_left [NUM_ALARMS];
  logic [31:0] alm_per [NUM_ALARMS];
  logic [2:0]  alm_own [NUM_ALARMS];

  outcome_t pending_results [$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       expiries_seen = 0;
  int       items_sent = 0;
  longint   cycles = 0;

  counter_alarm_tick_engine_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  function automatic outcome_t mk(logic [1:0] st, logic [31:0] v, logic [31:0] nr,
                                  logic [3:0] a, logic ev, logic l);
    outcome_t o;
    o.status = st; o.value = v; o.nref = nr; o.alarm = a; o.exp_valid = ev; o.last = l;
    return o;
  endfunction

  // compute expected results and update predicted state
  task automatic predict_request(input logic [2:0] mode, input logic [2:0] cid,
                                 input logic [3:0] aidx, input logic [31:0] refv,
                                 input logic [31:0] cyc);
    int ncnt;
    int nal;
    logic [31:0] cur;
    ncnt = (p_ncnt < NUM_COUNTERS) ? p_ncnt : NUM_COUNTERS;
    nal = (p_nal < NUM_ALARMS) ? p_nal : NUM_ALARMS;
    if (mode > MODE_ARM) begin
      pending_results.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
    end else if (cid >= ncnt) begin
      pending_results.push_back(mk(ST_BAD_ID, 0, 0, 0, 0, 1));
    end else begin
      case (mode)
        MODE_TICK: begin
          cur = cnt_val[cid] + 1;
          if (cur > cnt_max[cid]) cur = 0;
          cnt_val[cid] = cur;
          for (int i = 0; i < nal; i++) begin
            if (alm_on[i] && alm_own[i] == cid) begin
              if (alm_left[i] > 0) alm_left[i]--;
              if (alm_left[i] == 0) begin
                pending_results.push_back(mk(ST_OK, 0, 0, i[3:0], 1, 0));
                if (alm_per[i] > 0) alm_left[i] = alm_per[i];
                else alm_on[i] = 1'b0;
              end
            end
          end
          pending_results.push_back(mk(ST_OK, cur, 0, 0, 0, 1));
        end
        MODE_READ: pending_results.push_back(mk(ST_OK, cnt_val[cid], 0, 0, 0, 1));
        MODE_ELAPSED: begin
          cur = cnt_val[cid];
          if (refv > cnt_max[cid])
            pending_results.push_back(mk(ST_BAD_REF, 0, 0, 0, 0, 1));
          else if (cur >= refv)
            pending_results.push_back(mk(ST_OK, cur - refv, cur, 0, 0, 1));
          else
            pending_results.push_back(mk(ST_OK, cnt_max[cid] - refv + cur + 1, cur, 0, 0, 1));
        end
        MODE_SETMAX: begin
          cnt_max[cid] = refv;
          cnt_val[cid] = 0;
          pending_results.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
        end
        default: begin
          alm_on[aidx] = 1'b1;
          alm_left[aidx] = refv;
          alm_per[aidx] = cyc;
          alm_own[aidx] = cid;
          pending_results.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
        end
      endcase
    end
  endtask

  // send one request with a random gap in front; valid stays up after acceptance
  // unless a gap or an idle phase follows
  task automatic send_request(input logic [2:0] mode, input logic [2:0] cid,
                              input logic [3:0] aidx, input logic [31:0] refv,
                              input logic [31:0] cyc);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_request(mode, cid, aidx, refv, cyc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, cyc, refv, aidx, cid, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // receiver: random stalls, compare against oldest expectation
  initial begin
    outcome_t w;
    int stall;
    forever begin
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("unexpected result %0d", results_seen);
      end else begin
        w = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== w.status) report("status", m_axis_tdata[1:0], w.status);
        if (m_axis_tdata[33:2] !== w.value) report("result_value", m_axis_tdata[33:2], w.value);
        if (m_axis_tdata[65:34] !== w.nref) report("new_reference", m_axis_tdata[65:34], w.nref);
        if (m_axis_tdata[69:66] !== w.alarm) report("expired_alarm", m_axis_tdata[69:66], w.alarm);
        if (m_axis_tuser !== w.exp_valid) report("expired_valid", m_axis_tuser, w.exp_valid);
        if (m_axis_tlast !== w.last) report("last", m_axis_tlast, w.last);
        if (w.exp_valid) expiries_seen++;
      end
    end
  end

  // stop sending, wait for all results, then settle, then write a register
  task automatic write_register(input logic idx, input logic [31:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_COUNTERS) p_ncnt = data[3:0];
    else p_nal = data[4:0];
  endtask

  task automatic test_directed();
    // field extremes and every mode
    send_request(MODE_READ, 3'd7, 4'd15, '1, '1);
    send_request(MODE_TICK, 3'd0, 4'd0, 0, 0);
    send_request(MODE_ELAPSED, 3'd0, 4'd0, 32'd5, 0);        // wrap-aware elapsed
    send_request(MODE_ELAPSED, 3'd0, 4'd0, 32'd1, 0);
    send_request(MODE_SETMAX, 3'd1, 4'd0, 32'd3, 0);
    send_request(MODE_ELAPSED, 3'd1, 4'd0, 32'd4, 0);        // reference above maximum
    send_request(MODE_ARM, 3'd1, 4'd0, 32'd0, 32'd0);        // zero ticks, single shot
    send_request(MODE_ARM, 3'd1, 4'd15, 32'd2, 32'd1);       // periodic
    send_request(MODE_ARM, 3'd1, 4'd7, 32'd1, '1);
    for (int i = 0; i < 5; i++) send_request(MODE_TICK, 3'd1, 4'd0, 0, 0); // wraps at 3
    send_request(MODE_ELAPSED, 3'd1, 4'd0, 32'd3, 0);
    send_request(3'd5, 3'd0, 4'd0, 0, 0);                    // unused modes
    send_request(3'd7, 3'd7, 4'd15, '1, '1);
    send_request(MODE_SETMAX, 3'd2, 4'd0, 32'd0, 0);         // maximum zero
    send_request(MODE_TICK, 3'd2, 4'd0, 0, 0);
    send_request(MODE_SETMAX, 3'd1, 4'd0, '1, 0);
  endtask

  task automatic test_config_extremes();
    write_register(CFG_COUNTERS, 32'd1);
    write_register(CFG_ALARMS, 32'd0);
    send_request(MODE_READ, 3'd1, 4'd0, 0, 0);               // bad counter id
    send_request(MODE_ARM, 3'd0, 4'd3, 0, 0);
    send_request(MODE_TICK, 3'd0, 4'd0, 0, 0);               // no alarms scanned
    write_register(CFG_COUNTERS, 32'hFFFF_FFFF);             // clamped
    write_register(CFG_ALARMS, 32'hFFFF_FFFF);
    send_request(MODE_TICK, 3'd0, 4'd0, 0, 0);
    send_request(MODE_TICK, 3'd7, 4'd0, 0, 0);
  endtask

  task automatic random_phase(input int n);
    logic [2:0] mode;
    logic [31:0] r;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = MODE_TICK;
        4: mode = MODE_READ;
        5: mode = MODE_ELAPSED;
        6: mode = MODE_SETMAX;
        7, 8: mode = MODE_ARM;
        default: mode = $urandom_range(0, 7);
      endcase
      r = $urandom();
      // keep maxima and alarm ticks small mostly so wraps and expiries happen
      if (mode != MODE_ELAPSED && $urandom_range(0, 5) != 0) r = $urandom_range(0, 6);
      send_request(mode, $urandom_range(0, 7), $urandom_range(0, 15), r,
                   ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 4));
    end
  endtask

  task automatic test_random();
    write_register(CFG_COUNTERS, 32'd8);
    write_register(CFG_ALARMS, 32'd16);
    random_phase(35);
    write_register(CFG_COUNTERS, 32'd5);
    write_register(CFG_ALARMS, 32'd9);
    random_phase(20);
    write_register(CFG_COUNTERS, 32'd8);
    write_register(CFG_ALARMS, 32'd16);
    random_phase(35);
  endtask

  initial begin
    p_ncnt = 4'd8;
    p_nal = 5'd16;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_val[i] = 0;
      cnt_max[i] = '1;
    end
    for (int i = 0; i < NUM_ALARMS; i++) begin
      alm_on[i] = 0; alm_left[i] = 0; alm_per[i] = 0; alm_own[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results including %0d alarm expiries",
             items_sent, results_seen, expiries_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/cate_pkg.sv
design/cate_front.sv
design/cate_back.sv
design/counter_alarm_tick_engine_unit.sv
verif/tb.sv
